// ===== rtl/push_pop_trace_structure_checker_unit_assert.svh =====
// Assertion macros for the trace checker
`ifndef PUSH_POP_TRACE_STRUCTURE_CHECKER_UNIT_ASSERT_SVH
`define PUSH_POP_TRACE_STRUCTURE_CHECKER_UNIT_ASSERT_SVH

// Implication checked every clock outside reset
`define PPTC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset
`define PPTC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/pptc_pkg.sv =====
`timescale 1ns / 1ps
package pptc_pkg;
	localparam int DEPTH_DEF      = 256;
	localparam int VALUE_BITS_DEF = 32;

	typedef enum logic [1:0] {
		CMD_PUSH    = 2'd0,
		CMD_POP     = 2'd1,
		CMD_RESTART = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		VERD_IMPOSSIBLE = 3'd0,
		VERD_STACK      = 3'd1,
		VERD_QUEUE      = 3'd2,
		VERD_HEAP       = 3'd3,
		VERD_UNSURE     = 3'd4
	} verdict_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_CHK,
		ST_HINS_RD,
		ST_HINS_CMP,
		ST_HREM_RD,
		ST_HREM_L,
		ST_HREM_CMP,
		ST_DONE
	} state_t;

	// Heap sifter request
	typedef struct packed {
		logic ins;
		logic rem;
	} heap_req_t;

	function automatic verdict_t verdict_of(input logic [2:0] f);
		verdict_t v;
		v = VERD_UNSURE;
		unique case (f)
			3'b000: v = VERD_IMPOSSIBLE;
			3'b001: v = VERD_STACK;
			3'b010: v = VERD_QUEUE;
			3'b100: v = VERD_HEAP;
			default: v = VERD_UNSURE;
		endcase
		return v;
	endfunction
endpackage

// ===== rtl/pptc_heap.sv =====
`timescale 1ns / 1ps
// Binary max-heap in a single-port synchronous memory. Insert sifts up,
// remove sifts down, one memory access per cycle.
module pptc_heap import pptc_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	localparam int AW        = $clog2(DEPTH),
	localparam int CW        = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  heap_req_t             req,
	input  logic [VALUE_BITS-1:0] din,
	input  logic                  clear,
	output logic [CW-1:0]         count,
	output logic [VALUE_BITS-1:0] top,
	output logic                  busy
);
	typedef enum logic [2:0] {
		H_IDLE, H_UP_RD, H_UP_CMP, H_DN_LAST, H_DN_L, H_DN_R, H_DN_CMP
	} hst_t;

	logic [VALUE_BITS-1:0] mem [DEPTH];
	logic [VALUE_BITS-1:0] rdata_q, cur_q, lval_q, top_q;
	logic [AW-1:0]         idx_q, lidx_q, raddr;
	logic [CW-1:0]         cnt_q;
	hst_t                  st_q, st_d;
	logic                  we, re, lok_q;
	logic [AW-1:0]         waddr;
	logic [VALUE_BITS-1:0] wdata;
	logic [CW:0]           l_w, r_w;
	logic [VALUE_BITS-1:0] sgn;
	logic                  dn_first;

	assign sgn   = {1'b1, {(VALUE_BITS-1){1'b0}}};
	assign count = cnt_q;
	assign top   = top_q;
	assign busy  = (st_q != H_IDLE);
	assign l_w   = (CW+1)'({idx_q, 1'b1});
	assign r_w   = l_w + 1'b1;
	// first pass of a removal: the moved last element is still in rdata_q
	assign dn_first = (idx_q == '0) && (lidx_q == '0);

	// Memory port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	always_comb begin
		st_d  = st_q;
		we    = 1'b0;
		re    = 1'b0;
		waddr = idx_q;
		wdata = cur_q;
		raddr = idx_q;
		unique case (st_q)
			H_IDLE: begin
				if (req.ins) begin
					we = 1'b1; waddr = cnt_q[AW-1:0]; wdata = din;
					st_d = (cnt_q == '0) ? H_IDLE : H_UP_RD;
				end else if (req.rem) begin
					re = 1'b1; raddr = AW'(cnt_q - 1'b1);
					st_d = H_DN_LAST;
				end
			end
			H_UP_RD: begin
				// at the root the new element is written in place
				if (idx_q == '0) begin
					we = 1'b1; waddr = '0; wdata = cur_q;
					st_d = H_IDLE;
				end else begin
					re = 1'b1; raddr = AW'((idx_q - 1'b1) >> 1);
					st_d = H_UP_CMP;
				end
			end
			H_UP_CMP: begin
				if ((rdata_q ^ sgn) < (cur_q ^ sgn)) begin
					we = 1'b1; waddr = idx_q; wdata = rdata_q;
					st_d = H_UP_RD;
				end else begin
					we = 1'b1; waddr = idx_q; wdata = cur_q;
					st_d = H_IDLE;
				end
			end
			H_DN_LAST: begin
				// cur_q holds the moved element from the second level on
				if (l_w < (CW+1)'(cnt_q)) begin
					re = 1'b1; raddr = l_w[AW-1:0]; st_d = H_DN_L;
				end else begin
					we = 1'b1; wdata = dn_first ? rdata_q : cur_q; st_d = H_IDLE;
				end
			end
			H_DN_L: begin
				if (r_w < (CW+1)'(cnt_q)) begin
					re = 1'b1; raddr = r_w[AW-1:0];
				end
				st_d = H_DN_R;
			end
			H_DN_R: st_d = H_DN_CMP;
			H_DN_CMP: begin
				we = 1'b1;
				if (lok_q && (lval_q ^ sgn) > (cur_q ^ sgn)) begin
					wdata = lval_q; st_d = H_DN_LAST;
				end else begin
					st_d = H_IDLE;
				end
			end
			default: st_d = H_IDLE;
		endcase
	end

	// Sift control and bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= H_IDLE;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (clear) cnt_q <= '0;
			else if (st_q == H_IDLE && req.ins) cnt_q <= cnt_q + 1'b1;
			else if (st_q == H_IDLE && req.rem) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			H_IDLE: begin
				if (req.ins) begin
					cur_q <= din; idx_q <= cnt_q[AW-1:0];
					if (cnt_q == '0) top_q <= din;
				end else if (req.rem) begin
					idx_q <= '0;
				end
			end
			H_UP_CMP: begin
				if ((rdata_q ^ sgn) < (cur_q ^ sgn)) begin
					idx_q <= AW'((idx_q - 1'b1) >> 1);
					if (((idx_q - 1'b1) >> 1) == '0) top_q <= cur_q;
				end
			end
			H_DN_LAST: begin
				if (idx_q == '0) begin
					if (lidx_q == '0) begin
						cur_q <= rdata_q;
						if (!(l_w < (CW+1)'(cnt_q))) top_q <= rdata_q;
					end
				end
			end
			H_DN_L: begin
				lval_q <= rdata_q; lidx_q <= l_w[AW-1:0]; lok_q <= 1'b1;
				if (idx_q == '0) top_q <= cur_q;
			end
			H_DN_R: begin
				if (r_w < (CW+1)'(cnt_q) && (rdata_q ^ sgn) > (lval_q ^ sgn)) begin
					lval_q <= rdata_q; lidx_q <= r_w[AW-1:0];
				end
			end
			H_DN_CMP: begin
				if (lok_q && (lval_q ^ sgn) > (cur_q ^ sgn)) begin
					if (idx_q == '0) top_q <= lval_q;
					idx_q <= lidx_q;
				end
				lidx_q <= lidx_q;
			end
			default: ;
		endcase
		if (st_q == H_IDLE && req.rem) lidx_q <= '0;
		if (st_q == H_DN_LAST && idx_q != '0) lidx_q <= '1;
	end
endmodule

// ===== rtl/push_pop_trace_structure_checker_unit.sv =====
`timescale 1ns / 1ps
// Push/pop trace structure checker.
// Input channel (in_valid/in_ready): cmd (0 push, 1 pop, 2 restart) and a
// signed value. Output channel (out_valid/out_ready): three possible flags
// (stack, queue, heap), a verdict and an overflow bit, one per transaction.
// Stack and queue live in their own synchronous memories; the heap lives in
// a third memory with a sequencer that sifts one level at a time.
// Transactions that skip the heap pass through the read, check and done
// states to the result register; a heap insert or removal also waits
// in its heap state until the sifter is idle. One transaction is in
// work at a time. The result sits in an output register; a new
// transaction is taken while that result waits, and the core stalls
// only if a second result is ready before the first is taken.
// Reset clears counts, pointers and flags (all three flags set); memory
// contents are not cleared; only entries inside the counts are used.
module push_pop_trace_structure_checker_unit import pptc_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        stack_possible,
	output logic        queue_possible,
	output logic        heap_possible,
	output logic [2:0]  verdict,
	output logic        overflow
);
	`include "push_pop_trace_structure_checker_unit_assert.svh"

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [VALUE_BITS-1:0] stk_mem [DEPTH];
	logic [VALUE_BITS-1:0] fifo_mem [DEPTH];
	logic [VALUE_BITS-1:0] stk_rd_q, fifo_rd_q, val_q;
	logic [CW-1:0]         stk_cnt_q, fifo_cnt_q;
	logic [AW-1:0]         head_q, tail_q;
	logic [2:0]            flags_q;
	cmd_t                  cmd_q;
	state_t                st_q, st_d;
	logic                  ovf_q;
	heap_req_t             hreq;
	logic [CW-1:0]         h_cnt;
	logic [VALUE_BITS-1:0] h_top;
	logic                  h_busy, h_clear, h_wait_q;
	logic                  accept, fire;

	assign accept   = in_valid && in_ready;
	assign in_ready = (st_q == ST_IDLE);
	assign fire     = (st_q == ST_DONE) && !(out_valid && !out_ready);

	pptc_heap #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS)) u_heap (
		.clk(clk), .arst_n(arst_n), .req(hreq), .din(val_q), .clear(h_clear),
		.count(h_cnt), .top(h_top), .busy(h_busy)
	);

	// Stack and queue memories
	always_ff @(posedge clk) begin
		if (st_q == ST_RD && cmd_q == CMD_PUSH && flags_q[0] && stk_cnt_q != CW'(DEPTH))
			stk_mem[stk_cnt_q[AW-1:0]] <= val_q;
		if (st_q == ST_RD && cmd_q == CMD_PUSH && flags_q[1] && fifo_cnt_q != CW'(DEPTH))
			fifo_mem[tail_q] <= val_q;
		if (st_q == ST_RD) begin
			stk_rd_q  <= stk_mem[AW'(stk_cnt_q - 1'b1)];
			fifo_rd_q <= fifo_mem[head_q];
		end
	end

	// Sequencer
	always_comb begin
		st_d    = st_q;
		hreq    = '0;
		h_clear = 1'b0;
		unique case (st_q)
			ST_IDLE: if (accept) st_d = ST_RD;
			ST_RD: st_d = ST_CHK;
			ST_CHK: begin
				unique case (cmd_q)
					CMD_PUSH: begin
						hreq.ins = flags_q[2] && h_cnt != CW'(DEPTH);
						st_d = hreq.ins ? ST_HINS_RD : ST_DONE;
					end
					CMD_POP: begin
						hreq.rem = flags_q[2] && h_cnt != '0 && h_top == val_q;
						st_d = hreq.rem ? ST_HREM_RD : ST_DONE;
					end
					CMD_RESTART: begin
						h_clear = 1'b1; st_d = ST_DONE;
					end
					default: st_d = ST_DONE;
				endcase
			end
			ST_HINS_RD, ST_HREM_RD: if (h_wait_q && !h_busy) st_d = ST_DONE;
			ST_DONE: if (fire) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			stk_cnt_q  <= '0;
			fifo_cnt_q <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			flags_q    <= 3'b111;
			out_valid  <= 1'b0;
			h_wait_q   <= 1'b0;
		end else begin
			st_q     <= st_d;
			h_wait_q <= (st_q == ST_HINS_RD || st_q == ST_HREM_RD);
			if (fire) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			if (st_q == ST_RD && cmd_q == CMD_PUSH) begin
				if (flags_q[0] && stk_cnt_q != CW'(DEPTH)) stk_cnt_q <= stk_cnt_q + 1'b1;
				if (flags_q[1] && fifo_cnt_q != CW'(DEPTH)) begin
					fifo_cnt_q <= fifo_cnt_q + 1'b1;
					tail_q <= (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
				end
			end
			if (st_q == ST_CHK) begin
				unique case (cmd_q)
					CMD_POP: begin
						if (flags_q[0]) begin
							if (stk_cnt_q == '0 || stk_rd_q != val_q) flags_q[0] <= 1'b0;
							else stk_cnt_q <= stk_cnt_q - 1'b1;
						end
						if (flags_q[1]) begin
							if (fifo_cnt_q == '0 || fifo_rd_q != val_q) flags_q[1] <= 1'b0;
							else begin
								fifo_cnt_q <= fifo_cnt_q - 1'b1;
								head_q <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
							end
						end
						if (flags_q[2] && (h_cnt == '0 || h_top != val_q))
							flags_q[2] <= 1'b0;
					end
					CMD_RESTART: begin
						stk_cnt_q <= '0; fifo_cnt_q <= '0;
						head_q <= '0; tail_q <= '0; flags_q <= 3'b111;
					end
					default: ;
				endcase
			end
		end
	end

	// Payload capture and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(cmd);
			val_q <= value[VALUE_BITS-1:0];
			ovf_q <= 1'b0;
		end
		if (st_q == ST_RD && cmd_q == CMD_PUSH)
			ovf_q <= (flags_q[0] && stk_cnt_q == CW'(DEPTH)) ||
				(flags_q[1] && fifo_cnt_q == CW'(DEPTH)) ||
				(flags_q[2] && h_cnt == CW'(DEPTH));
		if (fire) begin
			stack_possible <= flags_q[0];
			queue_possible <= flags_q[1];
			heap_possible  <= flags_q[2];
			verdict        <= verdict_of(flags_q);
			overflow       <= ovf_q;
		end
	end

	`PPTC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`PPTC_ASSERT_NEXT(a_fire_valid, fire, out_valid)
	`PPTC_ASSERT_IMP(a_cnt_range, 1'b1, stk_cnt_q <= CW'(DEPTH) && fifo_cnt_q <= CW'(DEPTH))
	`PPTC_ASSERT_IMP(a_heap_idle, st_q == ST_IDLE, !h_busy)
endmodule
